@@ rtl/core/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLIES(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error(msg);
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error(msg);
`else
`define ASSERT_IMPLIES(label, clk_s, rst_s, ante, cons, msg)
`define ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg)
`endif

`endif

@@ rtl/core/mh2_pkg.sv @@
// ----------------------------------------------------------------------------
// MurmurHash2 package
// Shared constants, sequencer states and the controller/datapath interface.
// ----------------------------------------------------------------------------
package mh2_pkg;

    localparam logic [31:0] MUR_M = 32'h5bd1e995;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MIX_H,
        ST_MIX_K,
        ST_MIX_KX,
        ST_MIX_FOLD,
        ST_TAIL_MUL,
        ST_TAIL_FOLD,
        ST_FIN_MUL,
        ST_FIN_OUT
    } mh2_state_t;

    // Operand choice for the shared multiplier.
    typedef enum logic [2:0] {
        MUL_H,
        MUL_K,
        MUL_KMIX,
        MUL_TAIL,
        MUL_FIN
    } mh2_mul_sel_t;

    typedef struct packed {
        logic         load_item;
        logic         mul_en;
        mh2_mul_sel_t mul_sel;
        logic         h_load_mul;
        logic         h_xor_mul;
        logic         clr_buf;
        logic         out_load;
    } mh2_cmd_t;

    typedef struct packed {
        logic need_mix;
        logic tail_pending;
        logic out_free;
    } mh2_sts_t;

endpackage

@@ rtl/core/mh2_datapath.sv @@
// ----------------------------------------------------------------------------
// MurmurHash2 datapath
// Hash, byte packing and seed registers with one shared multiply-by-M unit.
// ----------------------------------------------------------------------------
module mh2_datapath
    import mh2_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic [31:0] hash_seed,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        first_item,
    input  logic        last_item,
    input  logic [31:0] message_length,
    input  logic        out_ready,
    output logic        out_valid,
    output logic [31:0] hash_value,
    input  mh2_cmd_t    cmd,
    output mh2_sts_t    sts
);

    logic [31:0] seed_reg;
    logic [31:0] h_reg,   h_next;
    logic [23:0] buf_reg, buf_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic [31:0] k_reg,   k_next;
    logic [31:0] mul_reg;
    logic [31:0] out_reg;
    logic        out_valid_reg, out_valid_next;

    logic [31:0] h_start;
    logic [23:0] buf_start;
    logic [1:0]  cnt_start;
    logic [23:0] buf_ins;
    logic [31:0] mul_a;
    logic [31:0] mul_prod;

    // State as seen after the first-item load of the incoming word.
    always_comb
    begin
        h_start   = first_item ? (seed_reg ^ message_length) : h_reg;
        buf_start = first_item ? 24'd0 : buf_reg;
        cnt_start = first_item ? 2'd0 : cnt_reg;
        buf_ins   = buf_start | ({16'd0, data_byte} << {cnt_start, 3'b000});
    end

    always_comb
    begin
        sts.need_mix     = byte_valid && (cnt_start == 2'd3);
        sts.tail_pending = last_item && !sts.need_mix && (byte_valid || (cnt_start != 2'd0));
        sts.out_free     = !out_valid_reg || out_ready;
    end

    always_comb
    begin
        case (cmd.mul_sel)
            MUL_H:    mul_a = h_reg;
            MUL_K:    mul_a = k_reg;
            MUL_KMIX: mul_a = mul_reg ^ (mul_reg >> 24);
            MUL_TAIL: mul_a = h_reg ^ {8'd0, buf_reg};
            MUL_FIN:  mul_a = h_reg ^ (h_reg >> 13);
            default:  mul_a = h_reg;
        endcase
        // Only the low 32 bits of the product are ever used.
        mul_prod = mul_a * MUR_M;
    end

    always_comb
    begin
        h_next         = h_reg;
        buf_next       = buf_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        out_valid_next = out_valid_reg;
        if (cmd.load_item)
        begin
            h_next   = h_start;
            buf_next = buf_start;
            cnt_next = cnt_start;
            k_next   = {data_byte, buf_start};
            if (byte_valid)
            begin
                if (cnt_start == 2'd3)
                begin
                    buf_next = 24'd0;
                    cnt_next = 2'd0;
                end
                else
                begin
                    buf_next = buf_ins;
                    cnt_next = cnt_start + 2'd1;
                end
            end
        end
        if (cmd.h_load_mul)
        begin
            h_next = mul_reg;
        end
        if (cmd.h_xor_mul)
        begin
            h_next = h_reg ^ mul_reg;
        end
        if (cmd.clr_buf)
        begin
            buf_next = 24'd0;
            cnt_next = 2'd0;
        end
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seed_reg      <= 32'd0;
            h_reg         <= 32'd0;
            buf_reg       <= 24'd0;
            cnt_reg       <= 2'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                seed_reg <= hash_seed;
            end
            h_reg         <= h_next;
            buf_reg       <= buf_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        k_reg <= k_next;
        if (cmd.mul_en)
        begin
            mul_reg <= mul_prod;
        end
        if (cmd.out_load)
        begin
            out_reg <= mul_reg ^ (mul_reg >> 15);
        end
    end

    assign out_valid  = out_valid_reg;
    assign hash_value = out_reg;

endmodule

@@ rtl/core/mh2_ctrl.sv @@
// ----------------------------------------------------------------------------
// MurmurHash2 controller
// Sequences word mixing, tail folding and finalization over the datapath.
// ----------------------------------------------------------------------------
module mh2_ctrl
    import mh2_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    input  logic     last_item,
    output logic     in_ready,
    input  mh2_sts_t sts,
    output mh2_cmd_t cmd
);

    mh2_state_t state_reg, state_next;
    logic       last_reg,  last_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            last_reg  <= last_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        last_next  = last_reg;
        in_ready   = 1'b0;
        cmd        = '{load_item: 1'b0, mul_en: 1'b0, mul_sel: MUL_H, h_load_mul: 1'b0,
                       h_xor_mul: 1'b0, clr_buf: 1'b0, out_load: 1'b0};
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    last_next     = last_item;
                    if (sts.need_mix)
                    begin
                        state_next = ST_MIX_H;
                    end
                    else if (last_item)
                    begin
                        state_next = sts.tail_pending ? ST_TAIL_MUL : ST_FIN_MUL;
                    end
                end
            end
            ST_MIX_H:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_H;
                state_next  = ST_MIX_K;
            end
            ST_MIX_K:
            begin
                cmd.h_load_mul = 1'b1;
                cmd.mul_en     = 1'b1;
                cmd.mul_sel    = MUL_K;
                state_next     = ST_MIX_KX;
            end
            ST_MIX_KX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_KMIX;
                state_next  = ST_MIX_FOLD;
            end
            ST_MIX_FOLD:
            begin
                cmd.h_xor_mul = 1'b1;
                state_next    = last_reg ? ST_FIN_MUL : ST_IDLE;
            end
            ST_TAIL_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_TAIL;
                state_next  = ST_TAIL_FOLD;
            end
            ST_TAIL_FOLD:
            begin
                cmd.h_load_mul = 1'b1;
                cmd.clr_buf    = 1'b1;
                state_next     = ST_FIN_MUL;
            end
            ST_FIN_MUL:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = MUL_FIN;
                cmd.clr_buf = 1'b1;
                state_next  = ST_FIN_OUT;
            end
            ST_FIN_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/core/murmur2_hash_32_top.sv @@
// ----------------------------------------------------------------------------
// MurmurHash2 32-bit top level
// Rate: one byte word per cycle while in_ready is high; a byte that completes
// a word stalls input for a mix of 3 multiplies. A last word goes to finalization
// directly with no pending bytes, after a tail fold with a tail, and after a mix
// when it completes a word; the hash waits while an earlier hash is still held in the output register.
// Reset (rst_n low, async) clears seed, running hash, packing state and out_valid.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module murmur2_hash_32_top
    import mh2_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write channel: the seed register.
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] hash_seed,
    // Input channel: one message byte per word.
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_valid,
    input  logic        first_item,
    input  logic        last_item,
    input  logic [31:0] message_length,
    // Output channel: one finished hash per message.
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] hash_value
);

    // The controller walks a short schedule over one shared 32x32 multiplier
    // whose product is always registered. A full word takes the multiplier
    // three times (hash times M, key times M, mixed key times M), then folds.
    // The tail fold and the finalization each use it once more. The output
    // register lets the next message start while a hash waits to be taken;
    // only a second finished hash waits for the first to drain.

    mh2_cmd_t cmd;
    mh2_sts_t sts;
    logic     in_fire;
    logic     plain_byte;
    logic     dp_busy;

    // The seed register is written whenever the host offers it.
    assign cfg_ready = 1'b1;

    mh2_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last_item (last_item),
        .in_ready  (in_ready),
        .sts       (sts),
        .cmd       (cmd)
    );

    mh2_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .hash_seed      (hash_seed),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .first_item     (first_item),
        .last_item      (last_item),
        .message_length (message_length),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .hash_value     (hash_value),
        .cmd            (cmd),
        .sts            (sts)
    );

    // Shorthands for the checks below.
    assign in_fire    = in_valid && in_ready;
    assign plain_byte = in_fire && !last_item && !sts.need_mix;
    assign dp_busy    = cmd.mul_en || cmd.out_load;

    // A last word always starts the finishing sequence, so input stalls next.
    `ASSERT_NEXT(a_last_stalls, clk, rst_n, in_fire && last_item, !in_ready, "last word not stalled")
    // A byte that neither completes a word nor ends a message leaves input ready in the next cycle.
    `ASSERT_NEXT(a_byte_single, clk, rst_n, plain_byte, in_ready, "plain byte not single cycle")
    // The multiplier stays quiet while the block waits for input.
    `ASSERT_IMPLIES(a_idle_quiet, clk, rst_n, in_ready, !dp_busy, "datapath busy while idle")

endmodule

@@ dv/murmur2_hash_32_top_test.sv @@
// ----------------------------------------------------------------------------
// MurmurHash2 32-bit block test
// Streams byte messages into the hash block with random sender bursts and
// receiver stalls. Each accepted word runs through a local hash model, and
// every emitted hash is compared with the oldest predicted one. The seed
// register is reprogrammed between phases, once the block has drained.
// ----------------------------------------------------------------------------
module murmur2_hash_32_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [31:0] MIX_MULT      = 32'h5bd1e995;
    localparam int          HALF_PERIOD   = 6;
    localparam int          RESET_CYCLES  = 12;
    // Cycles to let the block finish a word mix or a tail after the last
    // result has come back, before the seed may be touched.
    localparam int          SETTLE_CYCLES = 16;
    localparam int          STALL_LIMIT   = 2000;
    localparam int          MAX_REPORTS   = 40;
    localparam int          RANDOM_PHASES = 6;
    localparam int          PHASE_WORDS   = 235;

    // One input word as the sender presents it.
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        byte_valid;
        logic        first_item;
        logic        last_item;
        logic [31:0] message_length;
    } byte_word_t;

    // How the receiver behaves over its current stretch of cycles.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_CHOPPY,
        RX_HELD
    } rx_mode_t;

    logic        clk            = 1'b0;
    logic        rst_n          = 1'b0;
    logic        cfg_valid      = 1'b0;
    logic        cfg_ready;
    logic [31:0] hash_seed      = 32'h0;
    logic        in_valid       = 1'b0;
    logic        in_ready;
    logic [7:0]  data_byte      = 8'h0;
    logic        byte_valid     = 1'b0;
    logic        first_item     = 1'b0;
    logic        last_item      = 1'b0;
    logic [31:0] message_length = 32'h0;
    logic        out_valid;
    logic        out_ready      = 1'b0;
    logic [31:0] hash_value;

    // Words waiting to be sent, and hashes waiting to come back.
    byte_word_t  pending_words[$];
    logic [31:0] expected_hashes[$];

    // Local copy of the block's state: the seed register, the running hash
    // and the up to three bytes that have not yet made a full word.
    logic [31:0] predicted_seed = 32'h0;
    logic [31:0] running_hash   = 32'h0;
    logic [23:0] tail_bytes     = 24'h0;
    logic [1:0]  tail_count     = 2'd0;

    int unsigned error_count = 0;
    int unsigned idle_cycles = 0;

    murmur2_hash_32_top dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .hash_seed      (hash_seed),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .data_byte      (data_byte),
        .byte_valid     (byte_valid),
        .first_item     (first_item),
        .last_item      (last_item),
        .message_length (message_length),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .hash_value     (hash_value)
    );

    always #HALF_PERIOD clk = ~clk;

    // Prints one line per mismatch, up to a cap, and counts all of them.
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        error_count++;
        if (error_count <= MAX_REPORTS)
        begin
            $display("ERROR: %0t: %s: got %08h, expected %08h", $realtime, what, got, want);
        end
    endtask

    // Key scramble applied to every full 32-bit word before it is folded in.
    function automatic logic [31:0] scramble_key(input logic [31:0] key);
        logic [31:0] k;
        k = key * MIX_MULT;
        k = k ^ (k >> 24);
        k = k * MIX_MULT;
        return k;
    endfunction

    // Final avalanche that turns the running hash into the emitted value.
    function automatic logic [31:0] avalanche(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 13);
        t = t * MIX_MULT;
        t = t ^ (t >> 15);
        return t;
    endfunction

    // Advances the hash state by one accepted word. Within the word, the
    // restart on a first mark comes before the byte is taken, and the finish
    // on a last mark comes after it, so one word can carry a whole message.
    task automatic absorb_word(input byte_word_t w);
        logic [31:0] key;
        if (w.first_item)
        begin
            running_hash = predicted_seed ^ w.message_length;
            tail_bytes   = 24'h0;
            tail_count   = 2'd0;
        end
        if (w.byte_valid)
        begin
            if (tail_count == 2'd3)
            begin
                // Fourth byte completes a little-endian word.
                key          = {w.data_byte, tail_bytes};
                running_hash = (running_hash * MIX_MULT) ^ scramble_key(key);
                tail_bytes   = 24'h0;
                tail_count   = 2'd0;
            end
            else
            begin
                tail_bytes = tail_bytes | (24'(w.data_byte) << (8 * tail_count));
                tail_count = tail_count + 2'd1;
            end
        end
        if (w.last_item)
        begin
            // The tail is whatever bytes actually arrived, not what the
            // declared length says. The running hash keeps the folded tail.
            if (tail_count != 2'd0)
            begin
                running_hash = running_hash ^ {8'h0, tail_bytes};
                running_hash = running_hash * MIX_MULT;
            end
            expected_hashes.push_back(avalanche(running_hash));
            tail_bytes = 24'h0;
            tail_count = 2'd0;
        end
    endtask

    // Sender. It presents queued words in bursts of random length with random
    // gaps between them, holds a word steady until it is taken, and feeds every
    // accepted word to the hash model at the edge where it is accepted.
    always @(posedge clk or negedge rst_n)
    begin : sender
        byte_word_t  shown_word;
        logic        show;
        int unsigned burst_left;
        int unsigned gap_left;
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            burst_left = 0;
            gap_left   = 0;
        end
        else
        begin
            // A word that is up and not yet taken must stay up unchanged.
            show = in_valid && !in_ready;
            if (in_valid && in_ready)
            begin
                absorb_word(shown_word);
            end
            if (!show && pending_words.size() != 0)
            begin
                if (gap_left != 0)
                begin
                    gap_left--;
                end
                else
                begin
                    shown_word     = pending_words.pop_front();
                    data_byte      <= shown_word.data_byte;
                    byte_valid     <= shown_word.byte_valid;
                    first_item     <= shown_word.first_item;
                    last_item      <= shown_word.last_item;
                    message_length <= shown_word.message_length;
                    show = 1'b1;
                    if (burst_left <= 1)
                    begin
                        // Now and then a long burst with no gaps at all.
                        if ($urandom_range(0, 3) == 0)
                        begin
                            burst_left = $urandom_range(20, 80);
                        end
                        else
                        begin
                            burst_left = $urandom_range(1, 8);
                        end
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
                    end
                    else
                    begin
                        burst_left--;
                    end
                end
            end
            in_valid <= show;
        end
    end

    // Receiver. It switches between stretches of always ready, of random
    // ready, and of full stalls, and checks each hash taken against the
    // oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin : receiver
        logic [31:0] want;
        rx_mode_t    rx_mode;
        int unsigned rx_left;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            rx_mode   = RX_OPEN;
            rx_left   = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (expected_hashes.size() == 0)
                begin
                    report_mismatch("hash with no message pending", hash_value, 32'h0);
                end
                else
                begin
                    want = expected_hashes.pop_front();
                    if (hash_value !== want)
                    begin
                        report_mismatch("hash_value", hash_value, want);
                    end
                end
            end
            if (rx_left == 0)
            begin
                case ($urandom_range(0, 2))
                    0: rx_mode = RX_OPEN;
                    1: rx_mode = RX_CHOPPY;
                    default: rx_mode = RX_HELD;
                endcase
                rx_left = (rx_mode == RX_HELD) ? $urandom_range(1, 20) : $urandom_range(1, 60);
            end
            else
            begin
                rx_left--;
            end
            case (rx_mode)
                RX_OPEN:   out_ready <= 1'b1;
                RX_CHOPPY: out_ready <= 1'($urandom_range(0, 1));
                default:   out_ready <= 1'b0;
            endcase
        end
    end

    // Watchdog. A correct run never goes this long without some handshake.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            begin
                idle_cycles <= 0;
            end
            else if (idle_cycles + 1 >= STALL_LIMIT)
            begin
                $display("ERROR: no handshake for %0d cycles", STALL_LIMIT);
                $display("FAILED: results differ");
                $finish;
            end
            else
            begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    task automatic queue_word(input logic [7:0] b, input logic v, input logic f,
                              input logic l, input logic [31:0] len);
        byte_word_t w;
        w.data_byte      = b;
        w.byte_valid     = v;
        w.first_item     = f;
        w.last_item      = l;
        w.message_length = len;
        pending_words.push_back(w);
    endtask

    // Waits until every word has been taken and every hash has come back,
    // then gives the block time to finish work that produces no result.
    // The queues and in_valid are looked at on the falling edge, once the
    // sender's updates from the rising edge have all landed.
    task automatic wait_drained();
        while (pending_words.size() != 0 || in_valid || expected_hashes.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_seed(input logic [31:0] seed);
        @(posedge clk);
        cfg_valid <= 1'b1;
        hash_seed <= seed;
        do
        begin
            @(posedge clk);
        end
        while (!(cfg_valid && cfg_ready));
        predicted_seed = seed;
        cfg_valid <= 1'b0;
    endtask

    // Queues one message of n_bytes random bytes. A gappy message has words
    // without a byte scattered through it, sometimes with the last mark on
    // such a word. A message may also leave out its first mark and so carry
    // on from whatever came before.
    task automatic queue_message(input int unsigned n_bytes, input logic [31:0] declared,
                                 input bit gappy, input bit omit_first);
        byte_word_t msg[$];
        byte_word_t w;
        for (int unsigned i = 0; i < n_bytes; i++)
        begin
            if (gappy && $urandom_range(0, 4) == 0)
            begin
                w = '{data_byte: 8'($urandom), byte_valid: 1'b0, first_item: 1'b0,
                      last_item: 1'b0, message_length: $urandom};
                msg.push_back(w);
            end
            w = '{data_byte: 8'($urandom), byte_valid: 1'b1, first_item: 1'b0,
                  last_item: 1'b0, message_length: $urandom};
            msg.push_back(w);
        end
        if (n_bytes == 0 || (gappy && $urandom_range(0, 2) == 0))
        begin
            w = '{data_byte: 8'($urandom), byte_valid: 1'b0, first_item: 1'b0,
                  last_item: 1'b0, message_length: $urandom};
            msg.push_back(w);
        end
        // Only the word with the first mark has its length sampled.
        msg[0].first_item     = !omit_first;
        msg[0].message_length = declared;
        msg[msg.size() - 1].last_item = 1'b1;
        foreach (msg[i])
        begin
            pending_words.push_back(msg[i]);
        end
    endtask

    // Fills one phase with about target words: mostly whole messages with
    // random content, the rest single words with every field random.
    task automatic queue_random_phase(input int unsigned target);
        int unsigned start_size;
        int unsigned n_bytes;
        int unsigned pick;
        logic [31:0] declared;
        start_size = pending_words.size();
        while (pending_words.size() - start_size < target)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                queue_word(8'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), $urandom);
            end
            else
            begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                begin
                    n_bytes = $urandom_range(0, 8);
                end
                else if (pick < 9)
                begin
                    n_bytes = $urandom_range(9, 24);
                end
                else
                begin
                    n_bytes = $urandom_range(25, 64);
                end
                declared = ($urandom_range(0, 4) == 0) ? $urandom : n_bytes;
                queue_message(n_bytes, declared, $urandom_range(0, 3) == 0,
                              $urandom_range(0, 19) == 0);
            end
        end
    endtask

    initial
    begin
        logic [31:0] seed_plan[RANDOM_PHASES];
        seed_plan = '{32'hFFFF_FFFF, 32'h0000_0000, $urandom, 32'h8000_0000, $urandom,
                      32'h0000_0001};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed messages under the reset seed.
        // Empty messages, with the smallest and the largest declared length.
        queue_word(8'h00, 1'b0, 1'b1, 1'b1, 32'h0000_0000);
        queue_word(8'hFF, 1'b0, 1'b1, 1'b1, 32'hFFFF_FFFF);
        // A whole one-byte message in a single word.
        queue_word(8'hFF, 1'b1, 1'b1, 1'b1, 32'h0000_0001);
        // One full word of all-ones bytes plus a one-byte tail.
        queue_word(8'hFF, 1'b1, 1'b1, 1'b0, 32'h0000_0005);
        repeat (3) queue_word(8'hFF, 1'b1, 1'b0, 1'b0, 32'h0000_0000);
        queue_word(8'hFF, 1'b1, 1'b0, 1'b1, 32'h0000_0000);
        // Exactly one word of zero bytes, with a declared length that is wrong.
        queue_word(8'h00, 1'b1, 1'b1, 1'b0, 32'd1000);
        repeat (2) queue_word(8'h00, 1'b1, 1'b0, 1'b0, 32'h0000_0000);
        queue_word(8'h00, 1'b1, 1'b0, 1'b1, 32'h0000_0000);
        // A word without a byte in the middle, and the last mark on another
        // such word while three tail bytes are pending.
        queue_word(8'hA5, 1'b1, 1'b1, 1'b0, 32'h0000_0003);
        queue_word(8'h5A, 1'b0, 1'b0, 1'b0, 32'h0000_0000);
        queue_word(8'h3C, 1'b1, 1'b0, 1'b0, 32'h0000_0000);
        queue_word(8'hC3, 1'b1, 1'b0, 1'b0, 32'h0000_0000);
        queue_word(8'h7E, 1'b0, 1'b0, 1'b1, 32'h0000_0000);
        // A message without its first mark carries on from the last hash.
        queue_word(8'h11, 1'b1, 1'b0, 1'b0, 32'h0000_0000);
        queue_word(8'h22, 1'b1, 1'b0, 1'b1, 32'h0000_0000);
        // A new first mark in the middle of a message restarts it.
        queue_word(8'h99, 1'b1, 1'b1, 1'b0, 32'h0000_0002);
        queue_word(8'h88, 1'b1, 1'b1, 1'b1, 32'h0000_0001);
        wait_drained();

        // Random phases. Between phases the sender holds back until every
        // hash has come home, and only then is the seed rewritten.
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            write_seed(seed_plan[p]);
            queue_random_phase(PHASE_WORDS);
            wait_drained();
        end

        if (expected_hashes.size() != 0)
        begin
            report_mismatch("hashes never emitted", 32'(expected_hashes.size()), 32'h0);
        end
        if (error_count == 0)
        begin
            $display("PASSED: all results match");
        end
        else
        begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl/core
rtl/core/mh2_pkg.sv
rtl/core/mh2_datapath.sv
rtl/core/mh2_ctrl.sv
rtl/core/murmur2_hash_32_top.sv
dv/murmur2_hash_32_top_test.sv
